FILE: src/winding_number_accumulator_defines.svh
// Assertion macros for the winding number accumulator.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef WINDING_NUMBER_ACCUMULATOR_DEFINES_SVH
`define WINDING_NUMBER_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define WNA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define WNA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/wna_pkg.sv
// Package for the winding number accumulator: widths, register indexes,
// CORDIC arctangent table. No dependencies.
`default_nettype none

package wna_pkg;

   // CORDIC step count (valid 8..32)
   localparam int CORDIC_ITERATIONS = 16;

   // Field and datapath widths
   localparam int COORD_W  = 24;  // Q15.8 coordinate
   localparam int D_W      = 25;  // vertex minus query
   localparam int SQ_W     = 50;  // squared length
   localparam int LEN_W    = 25;  // integer root of squared length
   localparam int REM_W    = 28;  // root / divider partial remainder
   localparam int QUO_BITS = 17;  // quotient bits of a unit component
   localparam int U_W      = 18;  // Q1.16 unit component, signed
   localparam int MUL_W    = 25;  // shared multiplier operand
   localparam int PROD_W   = 2 * MUL_W;
   localparam int CR_W     = 35;  // cross product component
   localparam int HALF_W   = 18;  // low half of a cross product component
   localparam int NUM_W    = 54;  // triple product, Q.48
   localparam int DEN_W    = 38;  // dot-sum term, Q.32
   localparam int CORD_W   = 58;  // CORDIC x / y
   localparam int ANG_W    = 26;  // angle in 2^-24 turn
   localparam int SUM_W    = 32;  // running sum
   localparam int WFULL_W  = SUM_W + 1 - 8;  // rounded sum before clamp
   localparam int WN_W     = 20;  // Q3.16 winding number
   localparam int THR_W    = 18;  // Q2.16 threshold, unsigned
   localparam int CNT_W    = 5;
   localparam int STEP_W   = 5;
   localparam int PROD_STEPS = 21;
   localparam int PADDR_W  = 4;
   localparam int PDATA_W  = 32;

   // Register indexes (paddr[3:2])
   localparam logic [1:0] REG_QUERY_X   = 2'd0;
   localparam logic [1:0] REG_QUERY_Y   = 2'd1;
   localparam logic [1:0] REG_QUERY_Z   = 2'd2;
   localparam logic [1:0] REG_THRESHOLD = 2'd3;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(32833);

   // atan(2^-k) in units of 2^-24 turn, rounded
   function automatic logic [ANG_W-1:0] atan_turns(input logic [4:0] k);
      logic [ANG_W-1:0] t;
      case (k)
         5'd0:    t = ANG_W'(2097152);
         5'd1:    t = ANG_W'(1238021);
         5'd2:    t = ANG_W'(654136);
         5'd3:    t = ANG_W'(332050);
         5'd4:    t = ANG_W'(166669);
         5'd5:    t = ANG_W'(83416);
         5'd6:    t = ANG_W'(41718);
         5'd7:    t = ANG_W'(20860);
         5'd8:    t = ANG_W'(10430);
         5'd9:    t = ANG_W'(5215);
         5'd10:   t = ANG_W'(2608);
         5'd11:   t = ANG_W'(1304);
         5'd12:   t = ANG_W'(652);
         5'd13:   t = ANG_W'(326);
         5'd14:   t = ANG_W'(163);
         5'd15:   t = ANG_W'(81);
         5'd16:   t = ANG_W'(41);
         5'd17:   t = ANG_W'(20);
         5'd18:   t = ANG_W'(10);
         5'd19:   t = ANG_W'(5);
         5'd20:   t = ANG_W'(3);
         5'd21:   t = ANG_W'(1);
         5'd22:   t = ANG_W'(1);
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

FILE: src/winding_number_accumulator.sv
// Winding number accumulator top level: sequencer, bit-serial root and divider,
// shared multiplier, iterative CORDIC. Depends on wna_pkg and the defines header.
//
// Usage:
//  - Triangles arrive on the req_ channel (valid/ready), one per transfer, with
//    req_last_triangle marking the final triangle of a mesh.
//  - A result transfer on the rsp_ channel follows only a last triangle; it
//    carries the rounded, clamped winding number, the inside bit and the clamp
//    flag. The running sum then restarts at zero.
//  - One triangle at a time: req_ready is high only when the sequencer is idle.
//    Per vertex it squares, takes the root and divides each component; then it
//    forms the products, folds the quadrant, runs the CORDIC and accumulates.
//    Triangles with a vertex on the query point or a zero numerator finish early.
//  - The result sits in an output register; if the receiver stalls, the block
//    keeps taking triangles and only waits when a next result is ready while the
//    old one is still not taken.
//  - Synchronous active-high reset clears the sum, the registers (threshold to its
//    default) and the handshakes. The user reads and writes registers over the
//    csr_ APB port at byte addresses 0, 4, 8, 12 only while idle; not enforced.
`default_nettype none
`include "winding_number_accumulator_defines.svh"

module winding_number_accumulator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [wna_pkg::COORD_W-1:0]     req_ax,
   input  logic signed [wna_pkg::COORD_W-1:0]     req_ay,
   input  logic signed [wna_pkg::COORD_W-1:0]     req_az,
   input  logic signed [wna_pkg::COORD_W-1:0]     req_bx,
   input  logic signed [wna_pkg::COORD_W-1:0]     req_by,
   input  logic signed [wna_pkg::COORD_W-1:0]     req_bz,
   input  logic signed [wna_pkg::COORD_W-1:0]     req_cx,
   input  logic signed [wna_pkg::COORD_W-1:0]     req_cy,
   input  logic signed [wna_pkg::COORD_W-1:0]     req_cz,
   input  logic                                   req_last_triangle,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [wna_pkg::WN_W-1:0]        rsp_winding_number,
   output logic                                   rsp_inside_res,
   output logic                                   rsp_saturated,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [wna_pkg::PADDR_W-1:0]            csr_paddr,
   input  logic [wna_pkg::PDATA_W-1:0]            csr_pwdata,
   output logic [wna_pkg::PDATA_W-1:0]            csr_prdata,
   output logic                                   csr_pready
);
   import wna_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_SQR   = 10'b00_0000_0010,
      ST_ROOT  = 10'b00_0000_0100,
      ST_DLD   = 10'b00_0000_1000,
      ST_DIV   = 10'b00_0001_0000,
      ST_PROD  = 10'b00_0010_0000,
      ST_CINIT = 10'b00_0100_0000,
      ST_CORD  = 10'b00_1000_0000,
      ST_ACC   = 10'b01_0000_0000,
      ST_FIN   = 10'b10_0000_0000
   } state_type;

   localparam logic [1:0]        LAST_IDX  = 2'd2;
   localparam logic [CNT_W-1:0]  SQR_LAST  = CNT_W'(3);
   localparam logic [CNT_W-1:0]  ROOT_LAST = CNT_W'(LEN_W - 1);
   localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(QUO_BITS - 1);
   localparam logic [CNT_W-1:0]  CORD_LAST = CNT_W'(CORDIC_ITERATIONS - 1);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PROD_STEPS);
   localparam logic signed [DEN_W-1:0]  DEN_ONE  = DEN_W'(64'h1_0000_0000);
   localparam logic signed [ANG_W-1:0]  ANG_HALF = ANG_W'(32'd8388608);
   localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [WN_W-1:0]   WN_MAX   = {1'b0, {(WN_W-1){1'b1}}};
   localparam logic signed [WN_W-1:0]   WN_MIN   = {1'b1, {(WN_W-1){1'b0}}};
   localparam logic signed [WFULL_W-1:0] WF_MAX  = WFULL_W'(WN_MAX);
   localparam logic signed [WFULL_W-1:0] WF_MIN  = WFULL_W'(WN_MIN);

   // Registers
   state_type                  state_ff, state_in;
   logic signed [COORD_W-1:0]  qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;
   logic [THR_W-1:0]           thr_ff, thr_in;
   logic signed [COORD_W-1:0]  coord_ff [0:2][0:2];
   logic signed [COORD_W-1:0]  coord_in [0:2][0:2];
   logic                       last_ff, last_in;
   logic [1:0]                 vtx_ff, vtx_in, comp_ff, comp_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [SQ_W-1:0]            sh_ff, sh_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [LEN_W-1:0]           qacc_ff, qacc_in, len_ff, len_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [U_W-1:0]      u_ff [0:2][0:2];
   logic signed [U_W-1:0]      u_in [0:2][0:2];
   logic signed [CR_W-1:0]     cr_ff [0:2];
   logic signed [CR_W-1:0]     cr_in [0:2];
   logic signed [NUM_W-1:0]    num_ff, num_in;
   logic signed [DEN_W-1:0]    den_ff, den_in;
   logic signed [CORD_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [ANG_W-1:0]    ang_ff, ang_in;
   logic signed [SUM_W-1:0]    angle_sum_ff, angle_sum_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [WN_W-1:0]     rsp_wn_ff, rsp_wn_in;
   logic                       rsp_inside_ff, rsp_inside_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   // Combinational datapath
   logic signed [COORD_W-1:0]  q_sel, c_sel;
   logic signed [D_W-1:0]      d_cur;
   logic [D_W-1:0]             d_mag;
   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic signed [PROD_W-1:0]   prod;
   logic [SQ_W-1:0]            s_next;
   logic [REM_W+1:0]           root_t, root_sub;
   logic [LEN_W-1:0]           root_next;
   logic [REM_W-1:0]           div_t;
   logic                       div_bit;
   logic [LEN_W-1:0]           quo_next;
   logic signed [U_W-1:0]      u_pos, u_val;
   logic [STEP_W-1:0]          pstep;
   logic signed [CORD_W-1:0]   x_init, y_init, x_sh, y_sh;
   logic signed [ANG_W-1:0]    turn;
   logic signed [SUM_W:0]      sum_ext, fin_t;
   logic signed [WFULL_W-1:0]  w_full;
   logic [WFULL_W-1:0]         w_mag;
   logic                       rsp_free, csr_wr;

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_winding_number = rsp_wn_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_saturated  = rsp_sat_ff;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // Register readback
   always_comb begin
      case (csr_paddr[3:2])
         REG_QUERY_X:   csr_prdata = PDATA_W'(unsigned'(qx_ff));
         REG_QUERY_Y:   csr_prdata = PDATA_W'(unsigned'(qy_ff));
         REG_QUERY_Z:   csr_prdata = PDATA_W'(unsigned'(qz_ff));
         REG_THRESHOLD: csr_prdata = PDATA_W'(thr_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // Current vertex component minus query point
   always_comb begin
      case (comp_ff)
         2'd0:    q_sel = qx_ff;
         2'd1:    q_sel = qy_ff;
         default: q_sel = qz_ff;
      endcase
   end
   assign c_sel = coord_ff[vtx_ff][comp_ff];
   assign d_cur = D_W'(c_sel) - D_W'(q_sel);
   assign d_mag = d_cur[D_W-1] ? D_W'(-d_cur) : D_W'(d_cur);

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_SQR) begin
         mul_a = d_cur;
         mul_b = d_cur;
      end else begin
         case (step_ff)
            5'd0:  begin mul_a = MUL_W'(u_ff[1][1]); mul_b = MUL_W'(u_ff[2][2]); end
            5'd1:  begin mul_a = MUL_W'(u_ff[1][2]); mul_b = MUL_W'(u_ff[2][1]); end
            5'd2:  begin mul_a = MUL_W'(u_ff[1][2]); mul_b = MUL_W'(u_ff[2][0]); end
            5'd3:  begin mul_a = MUL_W'(u_ff[1][0]); mul_b = MUL_W'(u_ff[2][2]); end
            5'd4:  begin mul_a = MUL_W'(u_ff[1][0]); mul_b = MUL_W'(u_ff[2][1]); end
            5'd5:  begin mul_a = MUL_W'(u_ff[1][1]); mul_b = MUL_W'(u_ff[2][0]); end
            5'd6:  begin
               mul_a = MUL_W'(u_ff[0][0]);
               mul_b = MUL_W'(signed'(cr_ff[0][CR_W-1:HALF_W]));
            end
            5'd7:  begin
               mul_a = MUL_W'(u_ff[0][1]);
               mul_b = MUL_W'(signed'(cr_ff[1][CR_W-1:HALF_W]));
            end
            5'd8:  begin
               mul_a = MUL_W'(u_ff[0][2]);
               mul_b = MUL_W'(signed'(cr_ff[2][CR_W-1:HALF_W]));
            end
            5'd9:  begin
               mul_a = MUL_W'(u_ff[0][0]);
               mul_b = signed'(MUL_W'(cr_ff[0][HALF_W-1:0]));
            end
            5'd10: begin
               mul_a = MUL_W'(u_ff[0][1]);
               mul_b = signed'(MUL_W'(cr_ff[1][HALF_W-1:0]));
            end
            5'd11: begin
               mul_a = MUL_W'(u_ff[0][2]);
               mul_b = signed'(MUL_W'(cr_ff[2][HALF_W-1:0]));
            end
            5'd12: begin mul_a = MUL_W'(u_ff[0][0]); mul_b = MUL_W'(u_ff[1][0]); end
            5'd13: begin mul_a = MUL_W'(u_ff[0][1]); mul_b = MUL_W'(u_ff[1][1]); end
            5'd14: begin mul_a = MUL_W'(u_ff[0][2]); mul_b = MUL_W'(u_ff[1][2]); end
            5'd15: begin mul_a = MUL_W'(u_ff[0][0]); mul_b = MUL_W'(u_ff[2][0]); end
            5'd16: begin mul_a = MUL_W'(u_ff[0][1]); mul_b = MUL_W'(u_ff[2][1]); end
            5'd17: begin mul_a = MUL_W'(u_ff[0][2]); mul_b = MUL_W'(u_ff[2][2]); end
            5'd18: begin mul_a = MUL_W'(u_ff[1][0]); mul_b = MUL_W'(u_ff[2][0]); end
            5'd19: begin mul_a = MUL_W'(u_ff[1][1]); mul_b = MUL_W'(u_ff[2][1]); end
            5'd20: begin mul_a = MUL_W'(u_ff[1][2]); mul_b = MUL_W'(u_ff[2][2]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end
   assign prod = mul_a * mul_b;

   // Squared length, root step, divider step
   assign s_next    = sh_ff + SQ_W'(prod_ff);
   assign root_t    = {rem_ff, sh_ff[SQ_W-1 -: 2]};
   assign root_sub  = (REM_W+2)'({qacc_ff, 2'b01});
   assign root_next = {qacc_ff[LEN_W-2:0], (root_t >= root_sub)};
   assign div_t     = {rem_ff[REM_W-2:0], sh_ff[SQ_W-1]};
   assign div_bit   = (div_t >= REM_W'(len_ff));
   assign quo_next  = {qacc_ff[LEN_W-2:0], div_bit};
   assign u_pos     = U_W'(quo_next[QUO_BITS-1:0]);
   assign u_val     = d_cur[D_W-1] ? -u_pos : u_pos;

   // CORDIC setup and step
   assign pstep  = step_ff - STEP_W'(1);
   assign x_init = CORD_W'(den_ff) <<< 16;
   assign y_init = CORD_W'(num_ff);
   assign x_sh   = x_ff >>> cnt_ff;
   assign y_sh   = y_ff >>> cnt_ff;
   assign turn   = signed'(atan_turns(cnt_ff));

   // Sum update and result rounding
   assign sum_ext = (SUM_W+1)'(angle_sum_ff) + (SUM_W+1)'(ang_ff);
   assign fin_t   = (SUM_W+1)'(angle_sum_ff) + (SUM_W+1)'(128);
   assign w_full  = fin_t[SUM_W:8];
   assign w_mag   = w_full[WFULL_W-1] ? WFULL_W'(-w_full) : WFULL_W'(w_full);

   // Sequencer and next-state datapath
   always_comb begin
      state_in     = state_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      qz_in        = qz_ff;
      thr_in       = thr_ff;
      coord_in     = coord_ff;
      last_in      = last_ff;
      vtx_in       = vtx_ff;
      comp_in      = comp_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      sh_in        = sh_ff;
      rem_in       = rem_ff;
      qacc_in      = qacc_ff;
      len_in       = len_ff;
      u_in         = u_ff;
      cr_in        = cr_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ang_in       = ang_ff;
      angle_sum_in = angle_sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_wn_in    = rsp_wn_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_sat_in   = rsp_sat_ff;

      // Register writes
      if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_QUERY_X:   qx_in  = signed'(csr_pwdata[COORD_W-1:0]);
            REG_QUERY_Y:   qy_in  = signed'(csr_pwdata[COORD_W-1:0]);
            REG_QUERY_Z:   qz_in  = signed'(csr_pwdata[COORD_W-1:0]);
            REG_THRESHOLD: thr_in = csr_pwdata[THR_W-1:0];
            default:       thr_in = thr_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               coord_in[0][0] = req_ax;
               coord_in[0][1] = req_ay;
               coord_in[0][2] = req_az;
               coord_in[1][0] = req_bx;
               coord_in[1][1] = req_by;
               coord_in[1][2] = req_bz;
               coord_in[2][0] = req_cx;
               coord_in[2][1] = req_cy;
               coord_in[2][2] = req_cz;
               last_in  = req_last_triangle;
               vtx_in   = '0;
               comp_in  = '0;
               cnt_in   = '0;
               sh_in    = '0;
               state_in = ST_SQR;
            end
         end
         // Sum of squares, one component per cycle through the multiplier
         ST_SQR: begin
            if (cnt_ff != '0) begin
               sh_in = s_next;
            end
            if (cnt_ff < CNT_W'(2)) begin
               comp_in = comp_ff + 2'd1;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == SQR_LAST) begin
               comp_in = '0;
               cnt_in  = '0;
               rem_in  = '0;
               qacc_in = '0;
               state_in = (s_next == '0) ? ST_FIN : ST_ROOT;
            end
         end
         // Integer square root, two radicand bits per cycle
         ST_ROOT: begin
            rem_in  = root_next[0] ? REM_W'(root_t - root_sub) : REM_W'(root_t);
            qacc_in = root_next;
            sh_in   = sh_ff << 2;
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == ROOT_LAST) begin
               len_in   = root_next;
               comp_in  = '0;
               state_in = ST_DLD;
            end
         end
         // Load the divider with the current component's magnitude
         ST_DLD: begin
            rem_in   = REM_W'(d_mag[D_W-1:1]);
            sh_in    = {d_mag[0], {(SQ_W-1){1'b0}}};
            qacc_in  = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         // Restoring division, one quotient bit per cycle
         ST_DIV: begin
            rem_in  = div_bit ? (div_t - REM_W'(len_ff)) : div_t;
            qacc_in = quo_next;
            sh_in   = sh_ff << 1;
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               u_in[vtx_ff][comp_ff] = u_val;
               cnt_in = '0;
               if (comp_ff != LAST_IDX) begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = ST_DLD;
               end else if (vtx_ff != LAST_IDX) begin
                  comp_in  = '0;
                  vtx_in   = vtx_ff + 2'd1;
                  sh_in    = '0;
                  state_in = ST_SQR;
               end else begin
                  comp_in  = '0;
                  step_in  = '0;
                  num_in   = '0;
                  den_in   = DEN_ONE;
                  state_in = ST_PROD;
               end
            end
         end
         // Triple product and dot sums, one product per cycle
         ST_PROD: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff != '0) begin
               case (pstep)
                  5'd0: cr_in[0] = CR_W'(prod_ff);
                  5'd1: cr_in[0] = cr_ff[0] - CR_W'(prod_ff);
                  5'd2: cr_in[1] = CR_W'(prod_ff);
                  5'd3: cr_in[1] = cr_ff[1] - CR_W'(prod_ff);
                  5'd4: cr_in[2] = CR_W'(prod_ff);
                  5'd5: cr_in[2] = cr_ff[2] - CR_W'(prod_ff);
                  default: begin
                     if (pstep inside {[5'd6:5'd8]}) begin
                        num_in = num_ff + (NUM_W'(prod_ff) <<< HALF_W);
                     end else if (pstep inside {[5'd9:5'd11]}) begin
                        num_in = num_ff + NUM_W'(prod_ff);
                     end else begin
                        den_in = den_ff + DEN_W'(prod_ff);
                     end
                  end
               endcase
            end
            if (step_ff == STEP_LAST) begin
               state_in = ST_CINIT;
            end
         end
         // Quadrant fold before the CORDIC steps
         ST_CINIT: begin
            cnt_in = '0;
            if (num_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               if (den_ff[DEN_W-1]) begin
                  x_in   = -x_init;
                  y_in   = -y_init;
                  ang_in = num_ff[NUM_W-1] ? -ANG_HALF : ANG_HALF;
               end else begin
                  x_in   = x_init;
                  y_in   = y_init;
                  ang_in = '0;
               end
               state_in = ST_CORD;
            end
         end
         // Vectoring CORDIC, one rotation per cycle
         ST_CORD: begin
            if (!y_ff[CORD_W-1]) begin
               x_in   = x_ff + y_sh;
               y_in   = y_ff - x_sh;
               ang_in = ang_ff + turn;
            end else begin
               x_in   = x_ff - y_sh;
               y_in   = y_ff + x_sh;
               ang_in = ang_ff - turn;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CORD_LAST) begin
               state_in = ST_ACC;
            end
         end
         // Saturating accumulate
         ST_ACC: begin
            if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
               angle_sum_in = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
            end else begin
               angle_sum_in = sum_ext[SUM_W-1:0];
            end
            state_in = ST_FIN;
         end
         // Return to idle; on the last triangle, emit the result first once the output slot is free
         ST_FIN: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = (w_mag > WFULL_W'(thr_ff));
               if (w_full > WF_MAX) begin
                  rsp_wn_in  = WN_MAX;
                  rsp_sat_in = 1'b1;
               end else if (w_full < WF_MIN) begin
                  rsp_wn_in  = WN_MIN;
                  rsp_sat_in = 1'b1;
               end else begin
                  rsp_wn_in  = w_full[WN_W-1:0];
                  rsp_sat_in = 1'b0;
               end
               angle_sum_in = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         qx_ff        <= '0;
         qy_ff        <= '0;
         qz_ff        <= '0;
         thr_ff       <= THR_RESET;
         angle_sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         qx_ff        <= qx_in;
         qy_ff        <= qy_in;
         qz_ff        <= qz_in;
         thr_ff       <= thr_in;
         angle_sum_ff <= angle_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      coord_ff      <= coord_in;
      last_ff       <= last_in;
      vtx_ff        <= vtx_in;
      comp_ff       <= comp_in;
      cnt_ff        <= cnt_in;
      step_ff       <= step_in;
      sh_ff         <= sh_in;
      rem_ff        <= rem_in;
      qacc_ff       <= qacc_in;
      len_ff        <= len_in;
      prod_ff       <= prod;
      u_ff          <= u_in;
      cr_ff         <= cr_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      ang_ff        <= ang_in;
      rsp_wn_ff     <= rsp_wn_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   // Checks
   `WNA_ASSERT_NXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == ST_SQR, "accepted triangle did not start the square phase")
   `WNA_ASSERT_IMP(a_div_rem_bound, clock, reset, state_ff == ST_DIV, rem_ff < REM_W'(len_ff), "divider remainder not below the length")
   `WNA_ASSERT_NXT(a_sum_cleared, clock, reset, state_ff == ST_FIN && last_ff && rsp_free, angle_sum_ff == '0 && rsp_valid_ff, "sum not cleared after result")
   `WNA_ASSERT_IMP(a_sat_clamped, clock, reset, rsp_valid_ff && rsp_sat_ff, rsp_wn_ff == WN_MAX || rsp_wn_ff == WN_MIN, "clamp flag without a clamped value")

endmodule

`default_nettype wire
